// File: src/kcc_pkg.sv
// ----------------------------------------------------------------------------
// kcc_pkg: shared types and constants
// Opcodes, register indexes and field widths of the keyed Caesar cipher.
// ----------------------------------------------------------------------------
package kcc_pkg;

   localparam int CHAR_W    = 8;
   localparam int OP_W      = 2;
   localparam int SHIFT_W   = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [CHAR_W-1:0]  ASCII_A     = 8'h41;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd3;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_KEY   = 2'd1,
      OP_SEAL  = 2'd2,
      OP_TEXT  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHIFT     = 1'b0,
      CSR_DIRECTION = 1'b1
   } csr_type;

endpackage

// File: src/kcc_ram.sv
// ----------------------------------------------------------------------------
// kcc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kcc_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 26
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/keyword_caesar_cipher.sv
// ----------------------------------------------------------------------------
// keyword_caesar_cipher: keyed Caesar cipher on uppercase ASCII
// Builds a permuted alphabet from a keyword and shifts text letters on it.
// ----------------------------------------------------------------------------
// usage
//   req channel: req_valid/req_stall with req_opcode and req_char_in.
//   clear restarts the keyword, key appends a new letter, seal fills the
//   remaining letters in order, text produces one byte on rsp.
//   rsp channel: rsp_valid/rsp_stall with rsp_char_out, held in an output
//   register until the transfer.
//   csr channel: csr_valid/csr_ready, index 0 shift, index 1 direction;
//   csr_ready is always high.
// timing
//   clear and key act on their transfer. seal fills letters after the
//   transfer, one letter per cycle through the placement port of the
//   two table RAMs.
//   a text letter passes two dependent registered RAM reads, then the
//   output register load; a passthrough byte skips the RAM reads.
//   a written shift is reduced by repeated subtraction of ALPHABET_SIZE,
//   one step per cycle while req_stall is high and no csr write comes in.
//   a stalled rsp holds the block in its output state until the transfer.
// reset
//   synchronous; clears the keyword, sealed flag, used flags, shift to 3,
//   direction to encrypt. table contents are written before being read.
// ----------------------------------------------------------------------------
module keyword_caesar_cipher #(
   parameter int ALPHABET_SIZE = 26
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [kcc_pkg::OP_W-1:0]       req_opcode,
   input  logic [kcc_pkg::CHAR_W-1:0]     req_char_in,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [kcc_pkg::CHAR_W-1:0]     rsp_char_out,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kcc_pkg::SHIFT_W-1:0]    csr_wdata
);

   import kcc_pkg::*;

   localparam int IDX_W  = $clog2(ALPHABET_SIZE);
   localparam int FILL_W = $clog2(ALPHABET_SIZE + 1);
   localparam int SUM_W  = IDX_W + 1;
   localparam int SHW1   = SHIFT_W + 1;

   localparam logic [FILL_W-1:0] N_FILL  = FILL_W'(ALPHABET_SIZE);
   localparam logic [SUM_W-1:0]  N_SUM   = SUM_W'(ALPHABET_SIZE);
   localparam logic [SHW1-1:0]   N_SHIFT = SHW1'(ALPHABET_SIZE);
   localparam logic [IDX_W-1:0]  IDX_MAX = IDX_W'(ALPHABET_SIZE - 1);
   localparam logic [CHAR_W-1:0] CHAR_END = CHAR_W'(ASCII_A + ALPHABET_SIZE);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEAL,
      ST_LOOK1,
      ST_LOOK2,
      ST_PUT
   } state_type;

   state_type                state_ff, state_in;
   logic [ALPHABET_SIZE-1:0] used_ff, used_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic                     sealed_ff, sealed_in;
   logic [IDX_W-1:0]         seal_idx_ff, seal_idx_in;
   logic [SHIFT_W-1:0]       shift_ff, shift_in;
   logic                     dir_ff, dir_in;
   logic [CHAR_W-1:0]        result_ff, result_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]        out_char_ff, out_char_in;

   logic                     shift_busy;
   logic                     is_letter;
   logic [IDX_W-1:0]         char_idx;
   logic                     place_req;
   logic [IDX_W-1:0]         place_idx;
   logic                     place_ok;
   logic [IDX_W-1:0]         pos_rd;
   logic [IDX_W-1:0]         letter_rd;
   logic [IDX_W-1:0]         shift_red;
   logic [SUM_W-1:0]         pos_sum;
   logic [IDX_W-1:0]         new_pos;

   assign shift_busy = {1'b0, shift_ff} >= N_SHIFT;
   assign is_letter  = (req_char_in >= ASCII_A) && (req_char_in < CHAR_END);
   assign char_idx   = IDX_W'(req_char_in - ASCII_A);
   assign place_ok   = place_req && !used_ff[place_idx] && (fill_ff < N_FILL);
   assign shift_red  = shift_ff[IDX_W-1:0];

   // position arithmetic, operands below ALPHABET_SIZE
   always_comb begin
      if (dir_ff) begin
         pos_sum = SUM_W'(pos_rd) + N_SUM - SUM_W'(shift_red);
      end else begin
         pos_sum = SUM_W'(pos_rd) + SUM_W'(shift_red);
      end
      if (pos_sum >= N_SUM) begin
         new_pos = IDX_W'(pos_sum - N_SUM);
      end else begin
         new_pos = IDX_W'(pos_sum);
      end
   end

   kcc_ram #(
      .WIDTH (IDX_W),
      .DEPTH (ALPHABET_SIZE)
   ) u_letter_pos (
      .clock   (clock),
      .wr_en   (place_ok),
      .wr_addr (place_idx),
      .wr_data (fill_ff[IDX_W-1:0]),
      .rd_addr (char_idx),
      .rd_data (pos_rd)
   );

   kcc_ram #(
      .WIDTH (IDX_W),
      .DEPTH (ALPHABET_SIZE)
   ) u_pos_letter (
      .clock   (clock),
      .wr_en   (place_ok),
      .wr_addr (fill_ff[IDX_W-1:0]),
      .wr_data (place_idx),
      .rd_addr (new_pos),
      .rd_data (letter_rd)
   );

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      fill_in      = fill_ff;
      sealed_in    = sealed_ff;
      seal_idx_in  = seal_idx_ff;
      shift_in     = shift_ff;
      dir_in       = dir_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      out_char_in  = out_char_ff;
      place_req    = 1'b0;
      place_idx    = seal_idx_ff;

      // config writes and shift reduction
      if (csr_valid) begin
         if (csr_index == CSR_SHIFT) begin
            shift_in = csr_wdata;
         end else begin
            dir_in = csr_wdata[0];
         end
      end else if (shift_busy) begin
         shift_in = SHIFT_W'({1'b0, shift_ff} - N_SHIFT);
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               case (op_type'(req_opcode))
                  OP_CLEAR: begin
                     used_in   = '0;
                     fill_in   = '0;
                     sealed_in = 1'b0;
                  end
                  OP_KEY: begin
                     place_idx = char_idx;
                     place_req = !sealed_ff && is_letter;
                  end
                  OP_SEAL: begin
                     if (!sealed_ff) begin
                        seal_idx_in = '0;
                        state_in    = ST_SEAL;
                     end
                  end
                  OP_TEXT: begin
                     if (sealed_ff && is_letter) begin
                        state_in = ST_LOOK1;
                     end else begin
                        result_in = req_char_in;
                        state_in  = ST_PUT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEAL: begin
            place_req   = 1'b1;
            seal_idx_in = seal_idx_ff + 1'b1;
            if (seal_idx_ff == IDX_MAX) begin
               sealed_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_LOOK1: begin
            state_in = ST_LOOK2;
         end
         ST_LOOK2: begin
            result_in = ASCII_A + CHAR_W'(letter_rd);
            state_in  = ST_PUT;
         end
         ST_PUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_char_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (place_ok) begin
         used_in[place_idx] = 1'b1;
         fill_in            = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         fill_ff      <= '0;
         sealed_ff    <= 1'b0;
         seal_idx_ff  <= '0;
         shift_ff     <= SHIFT_RESET;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         fill_ff      <= fill_in;
         sealed_ff    <= sealed_in;
         seal_idx_ff  <= seal_idx_in;
         shift_ff     <= shift_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff   <= result_in;
      out_char_ff <= out_char_in;
   end

   assign req_stall    = (state_ff != ST_IDLE) || shift_busy;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = out_char_ff;
   assign csr_ready    = 1'b1;

endmodule

// File: src/kcc_checker.sv
// ----------------------------------------------------------------------------
// kcc_checker: port-level checks for the keyed Caesar cipher
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module kcc_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [kcc_pkg::OP_W-1:0]   req_opcode,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [kcc_pkg::CHAR_W-1:0] rsp_char_out
);

   import kcc_pkg::*;

   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_char_out))
      else $error("rsp_char_out changed while stalled");

   // a text transfer keeps the request side busy for the following cycle
   a_text_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == OP_TEXT) |=> req_stall)
      else $error("request taken during text lookup");

   // nothing on the response side right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind keyword_caesar_cipher kcc_checker u_kcc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_opcode   (req_opcode),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_char_out (rsp_char_out)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: keyed Caesar cipher check
// Drives keywords, seals and text through the request channel under random
// gaps and response stalls, predicts every output byte from a private copy of
// the keyed alphabet and compares each response transfer in order.
// ----------------------------------------------------------------------------
module testbench;
   import kcc_pkg::*;

   localparam int LETTERS       = 26;
   localparam int RANDOM_ITEMS  = 700;
   localparam int SETTLE_CYCLES = 40;

   class cipher_scoreboard;
      logic [SHIFT_W-1:0] shift;
      logic               decrypt;
      logic [4:0]         pos_of_letter [LETTERS];
      logic [4:0]         letter_at_pos [LETTERS];
      bit                 used [LETTERS];
      int                 fill_count;
      bit                 sealed;
      logic [CHAR_W-1:0]  expected_chars [$];
      int                 errors;

      function new();
         shift = SHIFT_RESET;
         decrypt = 1'b0;
         fill_count = 0;
         sealed = 1'b0;
         errors = 0;
         foreach (used[i]) used[i] = 1'b0;
      endfunction

      function bit is_letter(logic [CHAR_W-1:0] c);
         return c >= ASCII_A && c < ASCII_A + LETTERS;
      endfunction

      function void place(int idx);
         if (used[idx] || fill_count >= LETTERS) return;
         pos_of_letter[idx] = fill_count[4:0];
         letter_at_pos[fill_count] = idx[4:0];
         used[idx] = 1'b1;
         fill_count++;
      endfunction

      function void write_reg(csr_type idx, logic [SHIFT_W-1:0] val);
         if (idx == CSR_SHIFT) shift = val;
         else decrypt = val[0];
      endfunction

      function void note_request(op_type op, logic [CHAR_W-1:0] ch);
         int s;
         int np;
         case (op)
            OP_CLEAR: begin
               foreach (used[i]) used[i] = 1'b0;
               fill_count = 0;
               sealed = 1'b0;
            end
            OP_KEY: begin
               if (!sealed && is_letter(ch)) place(int'(ch - ASCII_A));
            end
            OP_SEAL: begin
               if (!sealed) begin
                  for (int i = 0; i < LETTERS; i++) place(i);
                  sealed = 1'b1;
               end
            end
            default: begin
               if (!sealed || !is_letter(ch)) begin
                  expected_chars.push_back(ch);
               end else begin
                  s = shift % LETTERS;
                  np = int'(pos_of_letter[ch - ASCII_A]);
                  np = decrypt ? (np + LETTERS - s) % LETTERS : (np + s) % LETTERS;
                  expected_chars.push_back(ASCII_A + letter_at_pos[np]);
               end
            end
         endcase
      endfunction

      function void check_response(logic [CHAR_W-1:0] actual);
         logic [CHAR_W-1:0] want;
         if (expected_chars.size() == 0) begin
            $error("char_out expected none actual %h", actual);
            errors++;
            return;
         end
         want = expected_chars.pop_front();
         if (want !== actual) begin
            $error("char_out expected %h actual %h", want, actual);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OP_W-1:0]      req_opcode = OP_CLEAR;
   logic [CHAR_W-1:0]    req_char_in = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CHAR_W-1:0]    rsp_char_out;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SHIFT;
   logic [SHIFT_W-1:0]   csr_wdata = '0;

   cipher_scoreboard sb = new();
   int  items_sent;
   bit  calm;
   int  stall_pct = 20;
   int  stall_left;

   keyword_caesar_cipher u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_char_in  (req_char_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_out (rsp_char_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // receiver side: short random stalls with an occasional long one
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 199) == 0) begin
         stall_left = $urandom_range(10, 40);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_char_out);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_char(int pct);
      if ($urandom_range(0, 99) < pct) return ASCII_A + CHAR_W'($urandom_range(0, LETTERS - 1));
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   task automatic send(op_type op, logic [CHAR_W-1:0] ch);
      int gap;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_char_in <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, ch);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_type idx, logic [SHIFT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase();
      int key_len;
      if ($urandom_range(0, 9) < 8) begin
         send(OP_CLEAR, CHAR_W'($urandom_range(0, 255)));
         key_len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 32) : $urandom_range(0, 10);
         repeat (key_len) send(OP_KEY, pick_char(85));
         if ($urandom_range(0, 4) == 0) send(OP_TEXT, pick_char(70));
         send(OP_SEAL, CHAR_W'($urandom_range(0, 255)));
         if ($urandom_range(0, 3) == 0) send(OP_KEY, pick_char(90));
         if ($urandom_range(0, 5) == 0) send(OP_SEAL, CHAR_W'($urandom_range(0, 255)));
         repeat ($urandom_range(4, 30)) send(OP_TEXT, pick_char(85));
      end else begin
         repeat ($urandom_range(5, 20)) begin
            send(op_type'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings, keyword with repeats, lowercase and non-letters
      send(OP_TEXT, "M");
      send(OP_KEY, "Z");
      send(OP_KEY, "E");
      send(OP_KEY, "B");
      send(OP_KEY, "R");
      send(OP_KEY, "A");
      send(OP_KEY, "A");
      send(OP_KEY, "e");
      send(OP_KEY, 8'hFF);
      send(OP_KEY, 8'h00);
      send(OP_KEY, "[");
      send(OP_TEXT, "Z");
      send(OP_SEAL, 8'h00);
      send(OP_KEY, "Q");
      send(OP_SEAL, 8'hFF);
      send(OP_TEXT, "A");
      send(OP_TEXT, "Z");
      send(OP_TEXT, "Q");
      send(OP_TEXT, "@");
      send(OP_TEXT, "[");
      send(OP_TEXT, 8'h00);
      send(OP_TEXT, 8'hFF);
      send(OP_TEXT, "a");

      // shift and direction extremes
      settle();
      write_csr(CSR_SHIFT, 5'd0);
      send(OP_TEXT, "A");
      settle();
      write_csr(CSR_SHIFT, 5'd25);
      write_csr(CSR_DIRECTION, 5'd1);
      send(OP_TEXT, "Z");
      settle();
      write_csr(CSR_SHIFT, 5'd31);
      send(OP_TEXT, "B");
      settle();
      write_csr(CSR_SHIFT, 5'd26);
      write_csr(CSR_DIRECTION, 5'd0);
      send(OP_TEXT, "C");
      send(OP_CLEAR, 8'h00);
      send(OP_SEAL, 8'h00);
      send(OP_TEXT, "Y");

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 1) == 0) begin
            settle();
            write_csr(CSR_SHIFT, SHIFT_W'($urandom_range(0, 31)));
            write_csr(CSR_DIRECTION, SHIFT_W'($urandom_range(0, 31)));
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 10;
               2: stall_pct = 30;
               default: stall_pct = 60;
            endcase
         end
         random_phase();
      end

      settle();
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
src/kcc_pkg.sv
src/kcc_ram.sv
src/keyword_caesar_cipher.sv
src/kcc_checker.sv
tb/testbench.sv
